### rtl/page_frame_bitmap_allocator_assert.svh
// Assertion macros used by the controller of the page frame bitmap allocator.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define PFBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pfba assertion failed");
`define PFBA_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("pfba forbidden condition seen");
`else
`define PFBA_ASSERT(lbl, clk, rst_n, prop)
`define PFBA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/pfba_pkg.sv
// Types, constants and control structs of the page frame bitmap allocator.
package pfba_pkg;

	localparam int PAGE_COUNT = 8192;
	localparam int PAGE_BYTES = 4096;
	localparam int MAP_BYTES  = PAGE_COUNT / 8;
	localparam int MAP_AW     = $clog2(MAP_BYTES);
	localparam int PAGE_W     = $clog2(PAGE_COUNT);
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int ADDR_W     = 25;
	localparam int KIB_W      = 16;
	localparam int RES_W      = 14;
	localparam int CFG_IDX_W  = 2;
	localparam logic [7:0] BYTE_FULL = 8'hFF;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_MARK    = 2'd2,
		OP_INIT    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_RANGE  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEMORY_KIB     = 2'd0,
		REG_RESERVED_PAGES = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MODIFY,
		S_INIT
	} state_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_FILL,
		WR_INIT,
		WR_ALLOC,
		WR_MODIFY
	} wr_sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_SCAN,
		RD_PAGE
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    cnt_clr;
		logic    cnt_inc;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    res_en;
		status_t res_status;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic range_err;
		logic byte_full;
		logic cnt_last;
		logic rd_last;
	} dp_stat_t;

endpackage

### rtl/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator: controller, datapath and ports.
// Each accepted command passes the decode state, where an out-of-range release or
// mark ends; release and mark then read their byte and write it back, allocate
// scans to the first free bit or the last byte, and initialize writes every byte,
// both one byte per cycle; allocate reads over the single read port. A new command
// may start in the cycle that carries the done strobe. After reset busy stays high
// while a sweep marks every page used; configuration writes are taken at any time.
module page_frame_bitmap_allocator import pfba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Command channel: a transfer happens when start is high and busy is low.
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           operation,
	input  logic [31:0]          frame_address,
	input  logic [19:0]          page_index,
	// Result channel: one-cycle done strobe, the receiver cannot hold it off.
	output logic                 done,
	output logic [ADDR_W-1:0]    allocated_address,
	output logic [1:0]           status,
	// Configuration channel: a transfer happens when cfg_valid and cfg_ready are high.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// The registers are plain flops, so a configuration transfer is always accepted.
	assign cfg_ready = 1'b1;

	// The controller sequences the clear sweep, scans and read-modify-write steps.
	pfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// The datapath holds the bitmap, the byte counter and the result registers.
	pfba_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.operation         (operation),
		.frame_address     (frame_address),
		.page_index        (page_index),
		.cfg_we            (cfg_valid & cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.allocated_address (allocated_address),
		.status            (status),
		.done              (done)
	);

endmodule

### rtl/pfba_dp.sv
// Datapath of the page frame bitmap allocator: bitmap memory, counter and result registers.
module pfba_dp import pfba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat,
	input  logic [1:0]           operation,
	input  logic [31:0]          frame_address,
	input  logic [19:0]          page_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output logic [ADDR_W-1:0]    allocated_address,
	output logic [1:0]           status,
	output logic                 done
);

	logic [7:0] mem [MAP_BYTES];
	logic [7:0] rdata_q;
	logic [MAP_AW-1:0] rd_addr_q;
	logic [MAP_AW-1:0] cnt_q;

	logic [KIB_W-1:0] memory_kib_q;
	logic [RES_W-1:0] reserved_pages_q;

	op_t               op_q;
	logic              range_q;
	logic [PAGE_W-1:0] page_q;

	logic [ADDR_W-1:0] addr_q;
	status_t           status_q;
	logic              done_q;

	logic              rel_range, mark_range;
	logic [PAGE_W-1:0] in_page;
	logic [2:0]        free_bit;
	logic [7:0]        bit_mask;
	logic [7:0]        init_byte;
	logic [KIB_W+9:0]  kib_pages;
	logic [KIB_W+9:0]  free_bytes;
	logic [RES_W-4:0]  res_bytes;
	logic [7:0]        res_part;
	logic [PAGE_W-1:0] found_page;
	logic [PAGE_W+PAGE_SHIFT-1:0] found_addr;
	logic              we, re;
	logic [MAP_AW-1:0] waddr, raddr;
	logic [7:0]        wdata;

	// Range check and page number of the incoming item.
	assign rel_range  = (frame_address >> PAGE_SHIFT) >= 32'(PAGE_COUNT);
	assign mark_range = {1'b0, page_index} >= 21'(PAGE_COUNT);
	assign in_page    = (op_t'(operation) == OP_RELEASE) ?
		frame_address[PAGE_SHIFT +: PAGE_W] : page_index[PAGE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(operation);
			range_q <= (op_t'(operation) == OP_RELEASE) ? rel_range : mark_range;
			page_q  <= in_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_kib_q     <= KIB_W'(32768);
			reserved_pages_q <= RES_W'(1663);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MEMORY_KIB:     memory_kib_q <= cfg_data;
				REG_RESERVED_PAGES: reserved_pages_q <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Lowest clear bit of the byte just read.
	always_comb begin
		free_bit = '0;
		for (int i = 7; i >= 0; i--) begin
			if (!rdata_q[i]) free_bit = 3'(i);
		end
	end

	assign bit_mask   = 8'(1) << page_q[2:0];
	assign found_page = {rd_addr_q, free_bit};
	assign found_addr = {found_page, {PAGE_SHIFT{1'b0}}};

	// Byte value written by the initialize sweep.
	assign kib_pages  = {memory_kib_q, 10'b0} >> PAGE_SHIFT;
	assign free_bytes = kib_pages >> 3;
	assign res_bytes  = reserved_pages_q[RES_W-1:3];
	always_comb begin
		if (32'(cnt_q) < 32'(res_bytes)) begin
			res_part = BYTE_FULL;
		end else if (32'(cnt_q) == 32'(res_bytes)) begin
			res_part = 8'((9'd1 << reserved_pages_q[2:0]) - 9'd1);
		end else begin
			res_part = 8'h00;
		end
	end
	assign init_byte = ((32'(cnt_q) < 32'(free_bytes)) ? 8'h00 : BYTE_FULL) | res_part;

	always_comb begin
		we    = 1'b1;
		waddr = rd_addr_q;
		wdata = BYTE_FULL;
		unique case (cmd.wr_sel)
			WR_FILL: waddr = cnt_q;
			WR_INIT: begin
				waddr = cnt_q;
				wdata = init_byte;
			end
			WR_ALLOC:  wdata = rdata_q | (8'(1) << free_bit);
			WR_MODIFY: wdata = (op_q == OP_RELEASE) ? (rdata_q & ~bit_mask) :
				(rdata_q | bit_mask);
			default: we = 1'b0;
		endcase
	end

	assign re    = (cmd.rd_sel != RD_NONE);
	assign raddr = (cmd.rd_sel == RD_PAGE) ? page_q[PAGE_W-1:3] : cnt_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
		end else if (re) begin
			rd_addr_q <= raddr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			status_q <= cmd.res_status;
			addr_q   <= (cmd.wr_sel == WR_ALLOC) ? ADDR_W'(found_addr) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.res_en;
	end

	assign stat.op        = op_q;
	assign stat.range_err = range_q;
	assign stat.byte_full = (rdata_q == BYTE_FULL);
	assign stat.cnt_last  = (cnt_q == MAP_AW'(MAP_BYTES - 1));
	assign stat.rd_last   = (rd_addr_q == MAP_AW'(MAP_BYTES - 1));

	assign allocated_address = addr_q;
	assign status            = status_q;
	assign done              = done_q;

endmodule

### rtl/pfba_ctrl.sv
// Controller state machine of the page frame bitmap allocator.
`include "page_frame_bitmap_allocator_assert.svh"
module pfba_ctrl import pfba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (stat.cnt_last) state_d = S_IDLE;
			S_IDLE:  if (start) state_d = S_DECODE;
			S_DECODE: begin
				unique case (stat.op)
					OP_ALLOC: state_d = S_SCAN;
					OP_INIT:  state_d = S_INIT;
					default:  state_d = stat.range_err ? S_IDLE : S_MODIFY;
				endcase
			end
			S_SCAN:   if (!stat.byte_full || stat.rd_last) state_d = S_IDLE;
			S_MODIFY: state_d = S_IDLE;
			S_INIT:   if (stat.cnt_last) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_NONE;
		cmd.wr_sel     = WR_NONE;
		cmd.res_status = STAT_OK;
		busy           = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_sel  = WR_FILL;
				cmd.cnt_inc = 1'b1;
			end
			S_IDLE: begin
				busy        = 1'b0;
				cmd.load    = start;
				cmd.cnt_clr = start;
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_ALLOC: begin
						cmd.rd_sel  = RD_SCAN;
						cmd.cnt_inc = 1'b1;
					end
					OP_INIT: ;
					default: begin
						if (stat.range_err) begin
							cmd.res_en     = 1'b1;
							cmd.res_status = STAT_RANGE;
						end else begin
							cmd.rd_sel = RD_PAGE;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (!stat.byte_full) begin
					cmd.wr_sel = WR_ALLOC;
					cmd.res_en = 1'b1;
				end else if (stat.rd_last) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = STAT_NOFREE;
				end else begin
					cmd.rd_sel  = RD_SCAN;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_MODIFY: begin
				cmd.wr_sel = WR_MODIFY;
				cmd.res_en = 1'b1;
			end
			S_INIT: begin
				cmd.wr_sel  = WR_INIT;
				cmd.cnt_inc = 1'b1;
				cmd.res_en  = stat.cnt_last;
			end
			default: ;
		endcase
	end

	// Every result closes its item and leaves the controller idle.
	`PFBA_ASSERT(a_res_then_idle, clk, arst_n, cmd.res_en |=> state_q == S_IDLE)
	// The bitmap memory is never read and written in the same cycle.
	`PFBA_NEVER(a_no_rd_wr, clk, arst_n, cmd.rd_sel != RD_NONE && cmd.wr_sel != WR_NONE)
	// An accepted item is decoded in the next cycle.
	`PFBA_ASSERT(a_start_decode, clk, arst_n, (start && !busy) |=> state_q == S_DECODE)

endmodule

### sim/tb_page_frame_bitmap_allocator.sv
// Self-checking testbench for the page frame bitmap allocator, with directed and random commands.
module tb_page_frame_bitmap_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import pfba_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	// The tail wait after the last result covers one sweep through the whole
	// bitmap with some margin.
	localparam int TAIL_CYCLES = MAP_BYTES + 80;
	// The limit allows for every command walking the whole bitmap plus the
	// longest gaps, several times over.
	localparam longint TIMEOUT_NS = 64'd40_000_000;
	localparam int PHASES       = 8;
	localparam int PHASE_CMDS   = 70;
	localparam int MISMATCH_LOG = 10;

	// The register file decodes two index bits but only the two lowest indexes are in use.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		op_t         op;
		logic [31:0] frame_addr;
		logic [19:0] page_idx;
	} page_cmd_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} frame_result_t;

	// Clock, reset and the ports of the block. Every input has a known value from
	// time zero on.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           operation = OP_ALLOC;
	logic [31:0]          frame_address = '0;
	logic [19:0]          page_index = '0;
	logic                 done;
	logic [ADDR_W-1:0]    allocated_address;
	logic [1:0]           status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MEMORY_KIB;
	logic [15:0]          cfg_data = '0;

	// Shadow of the allocator: the bitmap and both configuration registers.
	logic [7:0]  frame_map [MAP_BYTES];
	int unsigned mem_kib_shadow;
	int unsigned reserved_shadow;

	// Commands waiting for the driver, and results owed by the block in order.
	page_cmd_t     cmd_backlog[$];
	frame_result_t owed_results[$];
	int            cmds_sent;
	int            cmds_taken;
	int            mismatches;

	// Driver state.
	page_cmd_t live_cmd;
	int        hold_off;
	int        burst_left;

	page_frame_bitmap_allocator u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.frame_address     (frame_address),
		.page_index        (page_index),
		.done              (done),
		.allocated_address (allocated_address),
		.status            (status),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Applies one command to the shadow bitmap and returns the result that the
	// block must give for it.
	function automatic frame_result_t frame_step(page_cmd_t c);
		frame_result_t r;
		int unsigned   limit;
		int unsigned   free_bytes;
		int unsigned   res;
		int unsigned   pg;
		int unsigned   b;
		int unsigned   k;
		bit            found;

		r.addr = '0;
		r.status = STAT_OK;
		case (c.op)
			OP_ALLOC: begin
				// First fit: skip full bytes, then take the lowest clear bit.
				found = 1'b0;
				pg = 0;
				for (b = 0; b < MAP_BYTES && !found; b++) begin
					if (frame_map[b] != BYTE_FULL) begin
						for (k = 0; k < 8 && !found; k++) begin
							if (!frame_map[b][k]) begin
								found = 1'b1;
								frame_map[b][k] = 1'b1;
								pg = b * 8 + k;
							end
						end
					end
				end
				if (found)
					r.addr = ADDR_W'(pg << PAGE_SHIFT);
				else
					r.status = STAT_NOFREE;
			end
			OP_RELEASE: begin
				pg = c.frame_addr >> PAGE_SHIFT;
				if (pg >= PAGE_COUNT)
					r.status = STAT_RANGE;
				else
					frame_map[pg / 8][pg % 8] = 1'b0;
			end
			OP_MARK: begin
				if (c.page_idx >= PAGE_COUNT)
					r.status = STAT_RANGE;
				else
					frame_map[c.page_idx / 8][c.page_idx % 8] = 1'b1;
			end
			default: begin
				// The usable limit is rounded down to whole bytes and saturates at
				// the bitmap size; reserved pages are then taken from the bottom.
				limit = (mem_kib_shadow * 1024) / PAGE_BYTES;
				if (limit > PAGE_COUNT)
					limit = PAGE_COUNT;
				free_bytes = limit / 8;
				for (b = 0; b < MAP_BYTES; b++)
					frame_map[b] = (b < free_bytes) ? 8'h00 : BYTE_FULL;
				res = reserved_shadow;
				if (res > PAGE_COUNT)
					res = PAGE_COUNT;
				for (pg = 0; pg < res; pg++)
					frame_map[pg / 8][pg % 8] = 1'b1;
			end
		endcase
		return r;
	endfunction

	// Picks a page near the boundary where allocation currently happens, or now
	// and then anywhere in the bitmap, so that releases and marks hit live pages.
	function automatic int unsigned pick_page();
		int unsigned base;

		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, PAGE_COUNT - 1);
		base = (reserved_shadow >= 8) ? reserved_shadow - 8 : 0;
		base = base + $urandom_range(0, 40);
		return (base >= PAGE_COUNT) ? PAGE_COUNT - 1 - $urandom_range(0, 7) : base;
	endfunction

	task automatic push_cmd(op_t op, logic [31:0] addr, logic [19:0] idx);
		page_cmd_t c;

		c.op = op;
		c.frame_addr = addr;
		c.page_idx = idx;
		cmd_backlog.push_back(c);
		cmds_sent++;
	endtask

	// One random command. Most are well formed and aimed at live pages; the rest
	// carry arbitrary addresses and indexes, mostly beyond the bitmap.
	task automatic push_random_cmd();
		int unsigned pick;
		int unsigned pg;

		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			push_cmd(OP_ALLOC, $urandom(), 20'($urandom()));
		end else if (pick < 65) begin
			pg = pick_page();
			push_cmd(OP_RELEASE, (pg << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1),
				20'($urandom()));
		end else if (pick < 78) begin
			pg = pick_page();
			push_cmd(OP_MARK, $urandom(), 20'(pg));
		end else if (pick < 83) begin
			push_cmd(OP_INIT, $urandom(), 20'($urandom()));
		end else if (pick < 92) begin
			push_cmd(OP_RELEASE, $urandom(), 20'($urandom()));
		end else begin
			push_cmd(OP_MARK, $urandom(), 20'($urandom_range(0, 20'hFFFFF)));
		end
	endtask

	// Waits until the driver has handed over every queued command and the block
	// has answered all of them. Each command gives exactly one result, so the
	// block is idle at that point.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmds_taken != cmds_sent || owed_results.size() != 0);
	endtask

	// One register write over the configuration channel. The shadow register
	// changes at the edge of the transfer; unknown indexes change nothing.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_MEMORY_KIB:     mem_kib_shadow = 32'(data);
			REG_RESERVED_PAGES: reserved_shadow = 32'(data[RES_W-1:0]);
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic program_limits(int unsigned kib, int unsigned res);
		cfg_write(REG_MEMORY_KIB, kib[15:0]);
		cfg_write(REG_RESERVED_PAGES, res[15:0]);
	endtask

	task automatic flag_mismatch(string what, frame_result_t want);
		if (mismatches < MISMATCH_LOG)
			$display("%0t: %s: expected addr %h status %0d, got addr %h status %0d",
				$realtime, what, want.addr, want.status, allocated_address, status);
		mismatches++;
	endtask

	// Command driver. A transfer happens at an edge where start is high and busy
	// is low; the expected result is worked out at that same edge. After each
	// transfer outside a burst the driver draws a random hold-off; during short
	// bursts commands follow back to back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			hold_off = 0;
			burst_left = 0;
		end else begin
			if (start && !busy) begin
				owed_results.push_back(frame_step(live_cmd));
				cmds_taken++;
				if (burst_left > 0) begin
					burst_left--;
					hold_off = 0;
				end else begin
					hold_off = $urandom_range(0, 3);
					if ($urandom_range(0, 9) == 0)
						burst_left = $urandom_range(4, 16);
				end
			end
			if (start && busy) begin
				// The command stays on the ports until the block takes it.
			end else if (hold_off > 0) begin
				hold_off--;
				start <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				live_cmd = cmd_backlog.pop_front();
				start <= 1'b1;
				operation <= live_cmd.op;
				frame_address <= live_cmd.frame_addr;
				page_index <= live_cmd.page_idx;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor. The done strobe lasts one cycle and cannot be held off, so
	// each result is taken at the edge that ends its cycle and compared with the
	// oldest owed result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_results.size() == 0)
				flag_mismatch("result with nothing owed", '{addr: '0, status: STAT_OK});
			else if (allocated_address !== owed_results[0].addr
				|| status !== owed_results[0].status)
				flag_mismatch("wrong result", owed_results.pop_front());
			else
				void'(owed_results.pop_front());
		end
	end

	// Run limit.
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		int unsigned phase_kib [PHASES];
		int unsigned phase_res [PHASES];
		int          ph;
		int          n;

		// Reset state: every page used and the registers at their reset values.
		foreach (frame_map[b])
			frame_map[b] = BYTE_FULL;
		mem_kib_shadow = 32768;
		reserved_shadow = 1663;
		cmds_sent = 0;
		cmds_taken = 0;
		mismatches = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the map as reset leaves it: the map is full, so the
		// first allocate finds nothing; releasing page 0 makes room for exactly one.
		push_cmd(OP_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF);
		push_cmd(OP_RELEASE, 32'h0000_0000, 20'h00000);
		push_cmd(OP_ALLOC, 32'h0000_0000, 20'h00000);
		// Addresses and indexes at and past the top of the bitmap.
		push_cmd(OP_RELEASE, 32'hFFFF_FFFF, 20'h00000);
		push_cmd(OP_RELEASE, 32'h0200_0000, 20'h00000);
		push_cmd(OP_RELEASE, 32'h01FF_FFFF, 20'h00000);
		push_cmd(OP_MARK, 32'h0000_0000, 20'hFFFFF);
		push_cmd(OP_MARK, 32'h0000_0000, 20'(PAGE_COUNT));
		push_cmd(OP_MARK, 32'h0000_0000, 20'(PAGE_COUNT - 1));
		// Marking a page that is already used changes nothing.
		push_cmd(OP_MARK, 32'h0000_0000, 20'h00000);
		// Initialize with the reset registers, then allocate just above the
		// reserved pages, release twice and mark back.
		push_cmd(OP_INIT, 32'h0000_0000, 20'h00000);
		push_cmd(OP_ALLOC, 32'h0000_0000, 20'h00000);
		push_cmd(OP_RELEASE, (32'd1663 << PAGE_SHIFT) | 32'hFFF, 20'h00000);
		push_cmd(OP_RELEASE, (32'd1663 << PAGE_SHIFT), 20'h00000);
		push_cmd(OP_MARK, 32'h0000_0000, 20'd1663);
		push_cmd(OP_ALLOC, 32'h0000_0000, 20'h00000);
		push_cmd(OP_ALLOC, 32'h0000_0000, 20'h00000);
		wait_drained();

		// Writes to the unused register indexes must leave both registers alone.
		cfg_write(REG_SPARE_LO, 16'($urandom()));
		cfg_write(REG_SPARE_HI, 16'($urandom()));

		// Register settings of the random phases. They cover no memory at all,
		// memory and reserve beyond capacity, a few pages with a limit that is
		// not a whole byte, a single free page at the very top, the reset setting and random mixes.
		phase_kib[0] = 0;     phase_res[0] = 0;
		phase_kib[1] = 65535; phase_res[1] = 16383;
		phase_kib[2] = 64;    phase_res[2] = 3;
		phase_kib[3] = 100;   phase_res[3] = 5;
		phase_kib[4] = 32768; phase_res[4] = PAGE_COUNT - 1;
		phase_kib[5] = $urandom_range(0, 32768);
		phase_res[5] = $urandom_range(0, PAGE_COUNT);
		phase_kib[6] = 32768; phase_res[6] = 1663;
		phase_kib[7] = $urandom_range(0, 65535);
		phase_res[7] = $urandom_range(0, PAGE_COUNT);

		for (ph = 0; ph < PHASES; ph++) begin
			program_limits(phase_kib[ph], phase_res[ph]);
			// Each phase begins from a freshly initialized map.
			push_cmd(OP_INIT, $urandom(), 20'($urandom()));
			for (n = 1; n < PHASE_CMDS; n++)
				push_random_cmd();
			wait_drained();
		end

		// Give a stray late strobe the chance to show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
